// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |-> (c)) else $error("assertion failed");
`define ASSERT_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |=> (c)) else $error("assertion failed");
`endif

// ===== src/bti_pkg.sv =====
// types and constants of the bilinear table interpolator
// no dependencies
package bti_pkg;
  localparam int WW = 24;
  localparam logic [1:0] FN_WR_ROW = 2'd0;
  localparam logic [1:0] FN_WR_COL = 2'd1;
  localparam logic [1:0] FN_WR_COEF = 2'd2;
  localparam logic [1:0] FN_QUERY = 2'd3;
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_OUT_FIRST = 2'd1;
  localparam logic [1:0] ST_OUT_SECOND = 2'd2;
  localparam logic [6:0] REG_ROWS = 7'd0;
  localparam logic [6:0] REG_COLS = 7'd1;

  typedef enum logic [4:0] {
    S_IDLE, S_WRITE,
    S_R_FIRST, S_R_FIRST_W, S_R_LAST, S_R_LAST_W, S_R_BIS, S_R_BIS_W,
    S_C_FIRST, S_C_FIRST_W, S_C_LAST, S_C_LAST_W, S_C_BIS, S_C_BIS_W,
    S_R_LO, S_R_HI, S_R_HI_W, S_C_LO, S_C_HI, S_C_HI_W,
    S_DIV_R, S_DIV_C, S_CORNER, S_ACC, S_OUT
  } state_t;
endpackage

// ===== src/bti_divider.sv =====
// restoring divider for q1.24 weights, one quotient bit per cycle
// depends on bti_pkg
module bti_divider import bti_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] num,
  input  logic [32:0] den,
  output logic        busy,
  output logic [WW:0] quot
);
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r;
  logic [WW:0] q_r, q_nxt;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [33:0] shifted;
  logic [33:0] trial;

  // numerator is at most the denominator, so the first step needs no shift
  always_comb begin
    shifted = (cnt_r == 6'(WW + 1)) ? rem_r : {rem_r[32:0], 1'b0};
    trial = shifted - {1'b0, den_r};
    if (!trial[33]) begin
      rem_nxt = trial;
      q_nxt = {q_r[WW-1:0], 1'b1};
    end else begin
      rem_nxt = shifted;
      q_nxt = {q_r[WW-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 6'(WW + 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r <= q_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
endmodule

// ===== src/bilinear_table_interpolator.sv =====
// bilinear interpolation over a loaded two-axis table
// channels: in_ items (writes or queries), out_ results, cfg_ register writes
// every item gives one result; a write passes the write state and then the
// output state, a query, at 64 points per axis, goes through these steps:
// per axis a search with 2 end reads and 6 bisection reads,
// per division two axis reads and 25 serial steps,
// and the four corner reads from the coefficient memory
// one item is in work at a time; in_ready is high only in the idle state,
// which the block enters in the cycle after the result is taken
// the result waits in the out_ registers until taken; a stalled receiver
// holds the block in the output state
// reset clears control and sets both used counts to their maximum; the
// memories are not cleared and must be written before they are read
// a coordinate outside its axis gives status 1 or 2 with zero fields
// depends on bti_pkg, bti_divider and assert_macros.svh
`include "assert_macros.svh"
module bilinear_table_interpolator import bti_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [5:0]  in_row_index,
  input  logic [5:0]  in_col_index,
  input  logic signed [31:0] in_axis_value,
  input  logic [31:0] in_coeff_value,
  input  logic signed [31:0] in_query_first,
  input  logic signed [31:0] in_query_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_interp_value,
  output logic [1:0]  out_status,
  output logic [5:0]  out_cell_row,
  output logic [5:0]  out_cell_col,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int NW = (RW > CW ? RW : CW) + 1;

  state_t state_r, state_nxt;
  logic [6:0] rows_r, cols_r;
  logic signed [31:0] row_mem [MAX_ROWS];
  logic signed [31:0] col_mem [MAX_COLS];
  logic [31:0] coef_mem [1 << (RW+CW)];

  logic [1:0]  func_r;
  logic [5:0]  ri_r, ci_r;
  logic [31:0] axv_r, cv_r;
  logic signed [31:0] qa_r, qb_r;
  logic [NW-1:0] nr, nc, lo_r, hi_r, mid;
  logic [RW-1:0] row_i_r;
  logic [CW-1:0] col_j_r;
  logic signed [31:0] rdr_r, rdc_r, a0_r, alast_r;
  logic [31:0] rdk_r;
  logic [WW:0] wx_r, wy_r;
  logic [1:0] k_r;
  logic [63:0] acc_r;
  logic [WW:0] cw_r;
  logic [31:0] res_v_r;
  logic [1:0]  res_s_r;
  logic [5:0]  res_r_r, res_c_r;
  logic        den_r_pos_r;

  function automatic logic [NW-1:0] clampn(input logic [6:0] v, input int mx);
    logic [NW-1:0] r;
    if (v < 7'd2) r = NW'(2);
    else if (int'(v) > mx) r = NW'(mx);
    else r = NW'(v);
    return r;
  endfunction

  assign nr = clampn(rows_r, MAX_ROWS);
  assign nc = clampn(cols_r, MAX_COLS);
  assign mid = NW'((lo_r + hi_r) >> 1);

  // axis reads
  logic [RW-1:0] raddr;
  logic [CW-1:0] caddr;
  always_comb begin
    raddr = RW'(mid);
    caddr = CW'(mid);
    unique case (state_r)
      S_R_FIRST: raddr = '0;
      S_R_LAST:  raddr = RW'(nr - NW'(1));
      S_R_LO:    raddr = row_i_r;
      S_R_HI:    raddr = RW'(row_i_r + RW'(1));
      S_C_FIRST: caddr = '0;
      S_C_LAST:  caddr = CW'(nc - NW'(1));
      S_C_LO:    caddr = col_j_r;
      S_C_HI:    caddr = CW'(col_j_r + CW'(1));
      default: ;
    endcase
  end

  logic [RW+CW-1:0] kaddr;
  always_comb begin
    kaddr = {RW'(row_i_r + RW'(k_r[1])), CW'(col_j_r + CW'(k_r[0]))};
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE && func_r == FN_WR_ROW && int'(ri_r) < MAX_ROWS)
      row_mem[RW'(ri_r)] <= axv_r;
    rdr_r <= row_mem[raddr];
  end
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE && func_r == FN_WR_COL && int'(ci_r) < MAX_COLS)
      col_mem[CW'(ci_r)] <= axv_r;
    rdc_r <= col_mem[caddr];
  end
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE && func_r == FN_WR_COEF && int'(ri_r) < MAX_ROWS
        && int'(ci_r) < MAX_COLS)
      coef_mem[{RW'(ri_r), CW'(ci_r)}] <= cv_r;
    rdk_r <= coef_mem[kaddr];
  end

  // divider
  logic        dv_start, dv_busy;
  logic [32:0] dv_num, dv_den;
  logic [WW:0] dv_q;
  logic signed [32:0] den_s, num_s;
  logic [WW:0] w_fin;
  logic signed [31:0] q_sel, hi_sel;
  assign q_sel = (state_r == S_R_HI_W) ? qa_r : qb_r;
  assign hi_sel = (state_r == S_R_HI_W) ? rdr_r : rdc_r;
  always_comb begin
    den_s = 33'(hi_sel) - 33'(a0_r);
    num_s = 33'(hi_sel) - 33'(q_sel);
    if (num_s < 0) num_s = '0;
    if (num_s > den_s) num_s = den_s;
    dv_num = num_s;
    dv_den = den_s;
  end
  assign dv_start = (state_r == S_R_HI_W || state_r == S_C_HI_W) && den_s > 0;
  assign w_fin = dv_q;

  bti_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .busy(dv_busy), .quot(dv_q)
  );

  // corner weight
  logic [2*WW+1:0] wprod;
  logic [WW:0] wa, wb;
  always_comb begin
    wa = k_r[1] ? (WW+1)'((1 << WW) - int'(wx_r)) : wx_r;
    wb = k_r[0] ? (WW+1)'((1 << WW) - int'(wy_r)) : wy_r;
    wprod = wa * wb;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = (in_func == FN_QUERY) ? S_R_FIRST : S_WRITE;
      S_WRITE: state_nxt = S_OUT;
      S_R_FIRST: state_nxt = S_R_FIRST_W;
      S_R_FIRST_W: state_nxt = (qa_r < rdr_r) ? S_OUT : S_R_LAST;
      S_R_LAST: state_nxt = S_R_LAST_W;
      S_R_LAST_W: state_nxt = (qa_r > rdr_r) ? S_OUT : S_R_BIS;
      S_R_BIS: state_nxt = (hi_r - lo_r > NW'(1)) ? S_R_BIS_W : S_C_FIRST;
      S_R_BIS_W: state_nxt = S_R_BIS;
      S_C_FIRST: state_nxt = S_C_FIRST_W;
      S_C_FIRST_W: state_nxt = (qb_r < rdc_r) ? S_OUT : S_C_LAST;
      S_C_LAST: state_nxt = S_C_LAST_W;
      S_C_LAST_W: state_nxt = (qb_r > rdc_r) ? S_OUT : S_C_BIS;
      S_C_BIS: state_nxt = (hi_r - lo_r > NW'(1)) ? S_C_BIS_W : S_R_LO;
      S_C_BIS_W: state_nxt = S_C_BIS;
      S_R_LO: state_nxt = S_R_HI;
      S_R_HI: state_nxt = S_R_HI_W;
      S_R_HI_W: state_nxt = S_DIV_R;
      S_DIV_R: if (!dv_busy) state_nxt = S_C_LO;
      S_C_LO: state_nxt = S_C_HI;
      S_C_HI: state_nxt = S_C_HI_W;
      S_C_HI_W: state_nxt = S_DIV_C;
      S_DIV_C: if (!dv_busy) state_nxt = S_CORNER;
      S_CORNER: state_nxt = S_ACC;
      S_ACC: state_nxt = (k_r == 2'd3) ? S_OUT : S_CORNER;
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    cfg_ready = (state_r == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rows_r <= 7'd64;
      cols_r <= 7'd64;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROWS) rows_r <= cfg_data;
        else if (cfg_index == REG_COLS) cols_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        func_r <= in_func; ri_r <= in_row_index; ci_r <= in_col_index;
        axv_r <= in_axis_value; cv_r <= in_coeff_value;
        qa_r <= in_query_first; qb_r <= in_query_second;
        res_v_r <= '0; res_s_r <= ST_DONE; res_r_r <= '0; res_c_r <= '0;
        lo_r <= '0; k_r <= '0; acc_r <= '0;
      end
      S_R_FIRST_W: begin
        a0_r <= rdr_r;
        if (qa_r < rdr_r) res_s_r <= ST_OUT_FIRST;
        lo_r <= '0; hi_r <= nr - NW'(1);
      end
      S_R_LAST_W: begin
        alast_r <= rdr_r;
        if (qa_r > rdr_r) res_s_r <= ST_OUT_FIRST;
      end
      S_R_BIS_W: if (qa_r >= rdr_r) lo_r <= mid; else hi_r <= mid;
      S_R_BIS: begin
        if (qa_r == a0_r) row_i_r <= '0;
        else if (qa_r == alast_r) row_i_r <= RW'(nr - NW'(2));
        else row_i_r <= RW'(lo_r);
      end
      S_C_FIRST_W: begin
        a0_r <= rdc_r;
        if (qb_r < rdc_r) res_s_r <= ST_OUT_SECOND;
        lo_r <= '0; hi_r <= nc - NW'(1);
      end
      S_C_LAST_W: begin
        alast_r <= rdc_r;
        if (qb_r > rdc_r) res_s_r <= ST_OUT_SECOND;
      end
      S_C_BIS_W: if (qb_r >= rdc_r) lo_r <= mid; else hi_r <= mid;
      S_C_BIS: begin
        if (qb_r == a0_r) col_j_r <= '0;
        else if (qb_r == alast_r) col_j_r <= CW'(nc - NW'(2));
        else col_j_r <= CW'(lo_r);
      end
      S_R_LO: ;
      S_R_HI: a0_r <= rdr_r;
      S_R_HI_W: if (!dv_start) wx_r <= (WW+1)'(1 << WW);
      S_DIV_R: if (!dv_busy && den_r_pos_r) wx_r <= w_fin;
      S_C_LO: ;
      S_C_HI: a0_r <= rdc_r;
      S_C_HI_W: if (!dv_start) wy_r <= (WW+1)'(1 << WW);
      S_DIV_C: if (!dv_busy && den_r_pos_r) wy_r <= w_fin;
      S_CORNER: cw_r <= (WW+1)'(wprod >> WW);
      S_ACC: begin
        acc_r <= acc_r + 64'(cw_r) * 64'(rdk_r);
        k_r <= k_r + 2'd1;
        if (k_r == 2'd3) begin
          res_v_r <= 32'((acc_r + 64'(cw_r) * 64'(rdk_r)) >> WW);
          res_r_r <= 6'(row_i_r);
          res_c_r <= 6'(col_j_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_R_HI_W || state_r == S_C_HI_W) den_r_pos_r <= dv_start;
  end

  assign out_interp_value = res_v_r;
  assign out_status = res_s_r;
  assign out_cell_row = res_r_r;
  assign out_cell_col = res_c_r;

  `ASSERT_IMPL(a_rdy_idle, in_ready, !out_valid)
  `ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_interp_value))
  `ASSERT_IMPL(a_err_zero, out_valid && out_status != ST_DONE, out_interp_value == '0)
endmodule
